// ===== sv/blpps_pkg.sv =====
package blpps_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int NAME_BYTES_DEF = 8;
    localparam int KEY_W          = 32;
    localparam int NAME_IN_W      = 64;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    localparam logic signed [KEY_W-1:0] KEY_FAIL = -32'sd1;
    localparam logic signed [KEY_W-1:0] KEY_NONE = 32'sd0;

    typedef enum logic [1:0] {
        OP_APPEND     = 2'd0,
        OP_POP_BACK   = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_SEARCH     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FETCH,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        op_t                     opcode;
        logic signed [KEY_W-1:0] key_in;
        logic [NAME_IN_W-1:0]    name_in;
    } req_t;

    typedef struct packed {
        logic                    status;
        logic signed [KEY_W-1:0] key_out;
        logic [NAME_IN_W-1:0]    name_out;
    } rsp_t;

endpackage

// ===== sv/blpps_ram.sv =====
module blpps_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/bounded_list_push_pop_search.sv =====
// Bounded ordered list kept as a ring buffer in one RAM with a registered read.
// An accepted request goes from execute to emit, through fetch for a successful removal
// and through a scan for a search, which compares one stored entry per cycle against a
// single shared comparator. One request is in flight at a time: a new request is taken
// only after emit has handed the last result on, and emit waits while the output is held.
// Reset (rst_n low, asynchronous) empties the list; RAM contents are not cleared.
module bounded_list_push_pop_search #(
    parameter int CAPACITY   = blpps_pkg::CAPACITY_DEF,
    parameter int NAME_BYTES = blpps_pkg::NAME_BYTES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  blpps_pkg::req_t req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output blpps_pkg::rsp_t rsp
);

    localparam int AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW     = $clog2(CAPACITY + 1);
    localparam int SW     = CW + 1;
    localparam int NAME_W = NAME_BYTES * 8;
    localparam int RW     = blpps_pkg::KEY_W + NAME_W;

    blpps_pkg::state_t state_reg, state_next;
    blpps_pkg::op_t    op_reg, op_next;
    logic signed [blpps_pkg::KEY_W-1:0] key_reg, key_next;
    logic [NAME_W-1:0] name_reg, name_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic              pend_reg, pend_next;
    blpps_pkg::rsp_t   res_reg, res_next;
    blpps_pkg::rsp_t   rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [RW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [RW-1:0]     ram_rdata;

    logic [blpps_pkg::NAME_IN_W-1:0] name_form;
    logic                            name_keep;
    logic [blpps_pkg::NAME_IN_W-1:0] rd_name_wide;
    logic [SW-1:0]     tail_sum;
    logic [SW-1:0]     last_sum;
    logic [AW-1:0]     tail_addr;
    logic [AW-1:0]     last_addr;
    logic              list_empty;
    logic              list_full;
    logic              name_hit;

    blpps_ram #(
        .WIDTH (RW),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // A name ends at its first zero byte and is cut to NAME_BYTES bytes.
    always_comb
    begin
        name_form = '0;
        name_keep = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            name_keep = name_keep && (req.name_in[8*i +: 8] != 8'd0) && (i < NAME_BYTES);
            if (name_keep)
            begin
                name_form[8*i +: 8] = req.name_in[8*i +: 8];
            end
        end
    end

    always_comb
    begin
        rd_name_wide             = '0;
        rd_name_wide[NAME_W-1:0] = ram_rdata[NAME_W-1:0];
    end

    // Ring positions of the slot after the last entry and of the last entry.
    always_comb
    begin
        tail_sum = SW'(head_reg) + SW'(count_reg);
        if (tail_sum >= SW'(CAPACITY))
        begin
            tail_sum = tail_sum - SW'(CAPACITY);
        end
        last_sum = SW'(head_reg) + SW'(count_reg) - SW'(1);
        if (last_sum >= SW'(CAPACITY))
        begin
            last_sum = last_sum - SW'(CAPACITY);
        end
        tail_addr = tail_sum[AW-1:0];
        last_addr = last_sum[AW-1:0];
    end

    assign list_empty = (count_reg == '0);
    assign list_full  = (count_reg == CW'(CAPACITY));
    assign name_hit   = (ram_rdata[NAME_W-1:0] == name_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        name_next      = name_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        ram_we         = 1'b0;
        ram_waddr      = tail_addr;
        ram_wdata      = {key_reg, name_reg};
        ram_raddr      = ptr_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            blpps_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.opcode;
                    key_next   = req.key_in;
                    name_next  = name_form[NAME_W-1:0];
                    state_next = blpps_pkg::ST_EXEC;
                end
            end
            blpps_pkg::ST_EXEC:
            begin
                res_next.status   = blpps_pkg::STATUS_FAIL;
                res_next.key_out  = blpps_pkg::KEY_FAIL;
                res_next.name_out = '0;
                state_next        = blpps_pkg::ST_EMIT;
                unique case (op_reg)
                    blpps_pkg::OP_APPEND:
                    begin
                        if (!list_full)
                        begin
                            ram_we           = 1'b1;
                            count_next       = count_reg + 1'b1;
                            res_next.status  = blpps_pkg::STATUS_OK;
                            res_next.key_out = blpps_pkg::KEY_NONE;
                        end
                    end
                    blpps_pkg::OP_POP_BACK:
                    begin
                        if (!list_empty)
                        begin
                            ram_raddr  = last_addr;
                            count_next = count_reg - 1'b1;
                            state_next = blpps_pkg::ST_FETCH;
                        end
                    end
                    blpps_pkg::OP_POP_FRONT:
                    begin
                        if (!list_empty)
                        begin
                            ram_raddr  = head_reg;
                            head_next  = (head_reg == AW'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
                            count_next = count_reg - 1'b1;
                            state_next = blpps_pkg::ST_FETCH;
                        end
                    end
                    blpps_pkg::OP_SEARCH:
                    begin
                        idx_next   = '0;
                        ptr_next   = head_reg;
                        pend_next  = 1'b0;
                        state_next = blpps_pkg::ST_SCAN;
                    end
                    default:
                    begin
                        state_next = blpps_pkg::ST_EMIT;
                    end
                endcase
            end
            blpps_pkg::ST_FETCH:
            begin
                res_next.status   = blpps_pkg::STATUS_OK;
                res_next.key_out  = $signed(ram_rdata[RW-1:NAME_W]);
                res_next.name_out = rd_name_wide;
                state_next        = blpps_pkg::ST_EMIT;
            end
            blpps_pkg::ST_SCAN:
            begin
                // One read is issued per cycle; its data is compared on the next one.
                if (pend_reg && name_hit)
                begin
                    res_next.status   = blpps_pkg::STATUS_OK;
                    res_next.key_out  = $signed(ram_rdata[RW-1:NAME_W]);
                    res_next.name_out = '0;
                    state_next        = blpps_pkg::ST_EMIT;
                end
                else if (idx_reg == count_reg)
                begin
                    res_next.status   = blpps_pkg::STATUS_FAIL;
                    res_next.key_out  = blpps_pkg::KEY_FAIL;
                    res_next.name_out = '0;
                    state_next        = blpps_pkg::ST_EMIT;
                end
                else
                begin
                    ram_raddr = ptr_reg;
                    idx_next  = idx_reg + 1'b1;
                    ptr_next  = (ptr_reg == AW'(CAPACITY - 1)) ? '0 : ptr_reg + 1'b1;
                    pend_next = 1'b1;
                end
            end
            blpps_pkg::ST_EMIT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = blpps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = blpps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blpps_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            idx_reg       <= '0;
            ptr_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            ptr_reg       <= ptr_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        key_reg  <= key_next;
        name_reg <= name_next;
        res_reg  <= res_next;
        rsp_reg  <= rsp_next;
    end

    assign req_stall = (state_reg != blpps_pkg::ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == blpps_pkg::ST_EXEC)
        else $error("accepted request did not start execution");

    a_append_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == blpps_pkg::ST_EXEC && op_reg == blpps_pkg::OP_APPEND && !list_full
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("successful append did not grow the list");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == blpps_pkg::ST_SCAN |-> idx_reg <= count_reg)
        else $error("search walked past the last entry");

    a_fail_payload: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == blpps_pkg::STATUS_FAIL
        |-> rsp.key_out == blpps_pkg::KEY_FAIL && rsp.name_out == '0)
        else $error("failed request carries a payload");
`endif

endmodule

// ===== tb/tb_bounded_list_push_pop_search.sv =====
module tb_bounded_list_push_pop_search;
    timeunit 1ns;
    timeprecision 1ps;

    import blpps_pkg::*;

    localparam int RANDOM_ITEMS = 1750;
    localparam int TAIL_ITEMS   = 200;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    // Shadow copy of the list contents, front of the list at index 0.
    logic signed [KEY_W-1:0] stored_keys[$];
    logic [NAME_IN_W-1:0]    stored_names[$];

    req_t pending[$];
    rsp_t expected_replies[$];

    int items_accepted = 0;
    int total_items    = 0;
    int fail_count     = 0;
    int send_gap       = 0;
    bit send_idle_on   = 1'b0;
    bit quiet_tail     = 1'b0;
    int rx_cycle       = 0;
    int hold_left      = 0;
    int stall_left     = 0;
    int stall_mode     = 0;

    // Names that recur often enough for searches to hit stored entries.
    logic [NAME_IN_W-1:0] name_pool [8] = '{
        64'h0000_0000_0000_0041,
        64'h0000_0000_0042_4241,
        64'h4847_4645_4443_4241,
        64'hFFFF_FFFF_FFFF_FFFF,
        64'h0000_0000_0000_0000,
        64'h0000_006F_6C6C_6568,
        64'h0000_0000_0070_7564,
        64'h0000_0000_0000_00FF
    };

    bounded_list_push_pop_search dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        fail_count++;
        $display("%0t ns: mismatch, %s", $time, what);
    endtask

    // A name ends at its first zero byte; everything above it counts as zero.
    function automatic logic [NAME_IN_W-1:0] trim_name(input logic [NAME_IN_W-1:0] raw);
        logic [NAME_IN_W-1:0] trimmed;
        bit ended;
        int b;
        trimmed = '0;
        ended = 1'b0;
        for (b = 0; b < NAME_BYTES_DEF; b++)
        begin
            if (raw[8*b +: 8] == 8'h00)
                ended = 1'b1;
            if (!ended)
                trimmed[8*b +: 8] = raw[8*b +: 8];
        end
        return trimmed;
    endfunction

    function automatic rsp_t list_apply(input req_t r);
        rsp_t res;
        logic [NAME_IN_W-1:0] nm;
        bit found;
        int i;
        nm = trim_name(r.name_in);
        res.status = STATUS_FAIL;
        res.key_out = KEY_FAIL;
        res.name_out = '0;
        found = 1'b0;
        case (r.opcode)
            OP_APPEND:
                if (stored_keys.size() < CAPACITY_DEF)
                begin
                    stored_keys.push_back(r.key_in);
                    stored_names.push_back(nm);
                    res.status = STATUS_OK;
                    res.key_out = KEY_NONE;
                end
            OP_POP_BACK:
                if (stored_keys.size() > 0)
                begin
                    res.key_out = stored_keys.pop_back();
                    res.name_out = stored_names.pop_back();
                    res.status = STATUS_OK;
                end
            OP_POP_FRONT:
                if (stored_keys.size() > 0)
                begin
                    res.key_out = stored_keys.pop_front();
                    res.name_out = stored_names.pop_front();
                    res.status = STATUS_OK;
                end
            OP_SEARCH:
                for (i = 0; i < stored_names.size() && !found; i++)
                begin
                    if (stored_names[i] == nm)
                    begin
                        res.key_out = stored_keys[i];
                        res.status = STATUS_OK;
                        found = 1'b1;
                    end
                end
        endcase
        return res;
    endfunction

    function automatic void add_item(input op_t op, input logic signed [KEY_W-1:0] key,
                                     input logic [NAME_IN_W-1:0] name);
        req_t r;
        r.opcode = op;
        r.key_in = key;
        r.name_in = name;
        pending.push_back(r);
        total_items++;
    endfunction

    function automatic logic signed [KEY_W-1:0] pick_key();
        logic signed [KEY_W-1:0] k;
        case ($urandom_range(0, 7))
            0: k = KEY_FAIL;
            1: k = 32'sh7FFF_FFFF;
            2: k = 32'sh8000_0000;
            default: k = $urandom;
        endcase
        return k;
    endfunction

    function automatic logic [NAME_IN_W-1:0] pick_name();
        logic [NAME_IN_W-1:0] v;
        int n;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            v = name_pool[$urandom_range(0, 7)];
            // Junk above the terminator must not change which entry matches.
            if (sel < 2)
            begin
                n = 0;
                while (n < 8 && v[8*n +: 8] != 8'h00)
                    n++;
                if (n < 7)
                    v = v | ({$urandom, $urandom} << (8 * (n + 1)));
            end
        end
        else if (sel < 8)
        begin
            v = {$urandom, $urandom};
        end
        else
        begin
            v = {$urandom, $urandom};
            n = $urandom_range(0, 7);
            v[8*n +: 8] = 8'h00;
        end
        return v;
    endfunction

    // Request driver: holds each beat until the block takes it.
    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        req_t next_req;
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
            send_gap = 0;
            send_idle_on = 1'b0;
        end
        else
        begin
            next_valid = req_valid;
            next_req = req;
            if (req_valid && !req_stall)
            begin
                expected_replies.push_back(list_apply(req));
                items_accepted <= items_accepted + 1;
                next_valid = 1'b0;
                if (items_accepted % 64 == 0)
                    send_idle_on = $urandom_range(0, 1);
                if (send_idle_on && !quiet_tail && $urandom_range(0, 3) == 0)
                    send_gap = $urandom_range(1, 7);
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending.size() != 0)
                begin
                    next_req = pending.pop_front();
                    next_valid = 1'b1;
                end
            end
            req_valid <= next_valid;
            req <= next_req;
            quiet_tail <= (pending.size() < TAIL_ITEMS);
        end
    end

    // Result receiver: random stall bursts plus two long hold-offs that back
    // the block up into its request side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
            rx_cycle = 0;
            hold_left = 0;
            stall_left = 0;
            stall_mode = 0;
        end
        else
        begin
            rx_cycle++;
            if (rx_cycle % 128 == 0)
                stall_mode = $urandom_range(0, 2);
            if (rx_cycle == 2000 || rx_cycle == 7000)
                hold_left = 64;
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp_stall <= 1'b1;
            end
            else if (!quiet_tail && stall_mode != 0
                     && $urandom_range(0, (stall_mode == 2) ? 3 : 9) == 0)
            begin
                stall_left = $urandom_range(0, 6);
                rsp_stall <= 1'b1;
            end
            else
            begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // Result monitor.
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_replies.size() == 0)
            begin
                flag_mismatch($sformatf(
                    "result beat with nothing expected: status %0b key %0d name %h",
                    rsp.status, rsp.key_out, rsp.name_out));
            end
            else
            begin
                want = expected_replies.pop_front();
                if (rsp.status !== want.status)
                    flag_mismatch($sformatf("status got %0b want %0b", rsp.status, want.status));
                if (rsp.key_out !== want.key_out)
                    flag_mismatch($sformatf("key_out got %0d want %0d", rsp.key_out, want.key_out));
                if (rsp.name_out !== want.name_out)
                    flag_mismatch($sformatf("name_out got %h want %h",
                                            rsp.name_out, want.name_out));
            end
        end
    end

    initial
    begin
        int k;
        int r;
        int bias;
        int cut_append;
        int cut_back;
        int cut_front;
        op_t op;

        // Search and both removals on an empty list fail.
        add_item(OP_SEARCH, 32'sd0, 64'h0000_0000_0000_0041);
        add_item(OP_POP_BACK, 32'sd7, '1);
        add_item(OP_POP_FRONT, 32'sd7, '1);
        // Key extremes, a name with junk past its terminator, a duplicated name
        // whose first holder has key -1, and an empty name.
        add_item(OP_APPEND, 32'sh7FFF_FFFF, '1);
        add_item(OP_APPEND, 32'sh8000_0000, 64'h1122_3344_0055_6677);
        add_item(OP_APPEND, KEY_FAIL, 64'h0000_0000_0070_7564);
        add_item(OP_APPEND, 32'sd5, 64'h0000_0000_0070_7564);
        add_item(OP_APPEND, KEY_NONE, '0);
        for (k = 0; k < CAPACITY_DEF - 5; k++)
            add_item(OP_APPEND, $urandom, {32'h0, 24'h4C_4946, 8'h30 + 8'(k)});
        // The list is full now, so this append is refused.
        add_item(OP_APPEND, 32'sd99, 64'h0000_0000_0000_0041);
        add_item(OP_SEARCH, $urandom, 64'h9900_0000_0055_6677);
        add_item(OP_SEARCH, $urandom, 64'hDEAD_BEEF_0070_7564);
        add_item(OP_SEARCH, $urandom, 64'hFFFF_FFFF_FFFF_FF00);
        add_item(OP_SEARCH, $urandom, 64'h0000_0000_0000_0041);
        add_item(OP_POP_FRONT, $urandom, {$urandom, $urandom});
        add_item(OP_POP_BACK, $urandom, {$urandom, $urandom});

        // Random part in stretches that fill, drain, mix or mostly search.
        bias = 0;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k % 40 == 0)
                bias = $urandom_range(0, 3);
            case (bias)
                0:
                begin
                    cut_append = 65;
                    cut_back = 75;
                    cut_front = 85;
                end
                1:
                begin
                    cut_append = 20;
                    cut_back = 50;
                    cut_front = 80;
                end
                2:
                begin
                    cut_append = 35;
                    cut_back = 50;
                    cut_front = 65;
                end
                default:
                begin
                    cut_append = 30;
                    cut_back = 40;
                    cut_front = 50;
                end
            endcase
            r = $urandom_range(0, 99);
            if (r < cut_append)
                op = OP_APPEND;
            else if (r < cut_back)
                op = OP_POP_BACK;
            else if (r < cut_front)
                op = OP_POP_FRONT;
            else
                op = OP_SEARCH;
            add_item(op, pick_key(), pick_name());
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (items_accepted < total_items)
            @(posedge clk);
        while (expected_replies.size() != 0)
            @(posedge clk);
        // A search over a full list is the slowest request.
        repeat (CAPACITY_DEF + 8) @(posedge clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
sv/blpps_pkg.sv
sv/blpps_ram.sv
sv/bounded_list_push_pop_search.sv
tb/tb_bounded_list_push_pop_search.sv
